// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the Clarke-Park transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CPT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/cpt_pkg.sv =====
// Constants, types and the sine table generator for the Clarke-Park transform.
package cpt_pkg;

   localparam int SINE_INDEX_BITS_DEFAULT = 10;
   localparam int SAMPLE_BITS_DEFAULT     = 16;

   localparam int ANGLE_W = 16;
   localparam int TRIG_W  = 16;   // Q1.15 sine/cosine, signed
   localparam int ROM_W   = 15;   // magnitude 0..32767

   // Sine table is read in banks of BANK_DEPTH entries, each addressed by this many bits
   localparam int BANK_OFFSET_BITS = 8;
   localparam int BANK_DEPTH       = 1 << BANK_OFFSET_BITS;

   // Clarke coefficients in Q30, held as signed
   localparam int COEF_W = 31;
   localparam logic signed [COEF_W-1:0] THIRD_Q30     = 31'sd357913941;
   localparam logic signed [COEF_W-1:0] INV_SQRT3_Q30 = 31'sd619925131;
   localparam int CLARKE_SHIFT = 14;
   localparam int ROTATE_SHIFT = 31;

   // X and Y carry SAMPLE_BITS plus this many bits
   localparam int XY_EXTRA_BITS = 2 + COEF_W - CLARKE_SHIFT;

   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

   typedef struct packed {
      logic early;
      logic late;
   } cpt_stage_en_type;

   // Entry k of the quarter-wave table: Q30 Taylor series, rounded to Q15.
   function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned index_bits);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] entry;
      x    = (64'(k) * 64'(HALF_PI_Q30)) >> index_bits;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         unique case (n)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            6: term = term / 64'd156;
            7: term = term / 64'd210;
            default: term = term / 64'd272;
         endcase
         if ((n & 1) != 0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      entry = (sum + 64'sd16384) >>> 15;
      if (entry < 0) begin
         entry = '0;
      end
      if (entry > 64'sd32767) begin
         entry = 64'sd32767;
      end
      return entry[ROM_W-1:0];
   endfunction

endpackage

// ===== hdl/cpt_sine_rom.sv =====
// Banked quarter-wave sine table with quadrant folding, two register stages.
module cpt_sine_rom #(
   parameter int SINE_INDEX_BITS = cpt_pkg::SINE_INDEX_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  cpt_pkg::cpt_stage_en_type            advance,
   input  logic [1:0]                           quad,
   input  logic [SINE_INDEX_BITS-1:0]           k,
   output logic signed [cpt_pkg::TRIG_W-1:0]    sin_ff,
   output logic signed [cpt_pkg::TRIG_W-1:0]    cos_ff
);

   localparam int N      = 1 << SINE_INDEX_BITS;
   localparam int ADDR_W = SINE_INDEX_BITS + 1;
   localparam int NB     = (N + 1 + cpt_pkg::BANK_DEPTH - 1) / cpt_pkg::BANK_DEPTH;
   localparam int SEL_W  = (NB > 1) ? $clog2(NB) : 1;
   localparam int OFF_W  = cpt_pkg::BANK_OFFSET_BITS;
   localparam int ROM_W  = cpt_pkg::ROM_W;
   localparam int TRIG_W = cpt_pkg::TRIG_W;

   logic [ROM_W-1:0] rom_w [NB][cpt_pkg::BANK_DEPTH];

   for (genvar b = 0; b < NB; b++) begin : g_bank
      for (genvar e = 0; e < cpt_pkg::BANK_DEPTH; e++) begin : g_entry
         if (b * cpt_pkg::BANK_DEPTH + e <= N) begin : g_used
            assign rom_w[b][e] = cpt_pkg::sine_entry(b * cpt_pkg::BANK_DEPTH + e,
                                                     SINE_INDEX_BITS);
         end else begin : g_pad
            assign rom_w[b][e] = '0;
         end
      end
   end

   // T[k] and T[N-k] cover both sine and cosine in every quadrant
   logic [ADDR_W-1:0] addr_lo;
   logic [ADDR_W-1:0] addr_hi;
   logic [OFF_W-1:0]  off_lo;
   logic [OFF_W-1:0]  off_hi;

   assign addr_lo = {1'b0, k};
   assign addr_hi = ADDR_W'(N) - {1'b0, k};
   assign off_lo  = OFF_W'(addr_lo);
   assign off_hi  = OFF_W'(addr_hi);

   logic [ROM_W-1:0] bank_lo_in [NB];
   logic [ROM_W-1:0] bank_hi_in [NB];
   logic [ROM_W-1:0] bank_lo_ff [NB];
   logic [ROM_W-1:0] bank_hi_ff [NB];
   logic [SEL_W-1:0] sel_lo_in;
   logic [SEL_W-1:0] sel_hi_in;
   logic [SEL_W-1:0] sel_lo_ff;
   logic [SEL_W-1:0] sel_hi_ff;
   logic [1:0]       quad_ff;

   always_comb begin
      for (int b = 0; b < NB; b++) begin
         bank_lo_in[b] = rom_w[b][off_lo];
         bank_hi_in[b] = rom_w[b][off_hi];
      end
   end

   assign sel_lo_in = SEL_W'(addr_lo >> OFF_W);
   assign sel_hi_in = SEL_W'(addr_hi >> OFF_W);

   always_ff @(posedge clock) begin
      if (advance.early) begin
         for (int b = 0; b < NB; b++) begin
            bank_lo_ff[b] <= bank_lo_in[b];
            bank_hi_ff[b] <= bank_hi_in[b];
         end
         sel_lo_ff <= sel_lo_in;
         sel_hi_ff <= sel_hi_in;
         quad_ff   <= quad;
      end
   end

   logic [ROM_W-1:0]        t_lo;
   logic [ROM_W-1:0]        t_hi;
   logic [ROM_W-1:0]        sin_mag;
   logic [ROM_W-1:0]        cos_mag;
   logic signed [TRIG_W-1:0] sin_in;
   logic signed [TRIG_W-1:0] cos_in;

   assign t_lo    = bank_lo_ff[sel_lo_ff];
   assign t_hi    = bank_hi_ff[sel_hi_ff];
   assign sin_mag = quad_ff[0] ? t_hi : t_lo;
   assign cos_mag = quad_ff[0] ? t_lo : t_hi;

   // Cosine sits one quadrant ahead: negative in the second and third quadrants
   assign sin_in = quad_ff[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
   assign cos_in = (quad_ff[1] ^ quad_ff[0]) ? -$signed({1'b0, cos_mag})
                                             : $signed({1'b0, cos_mag});

   always_ff @(posedge clock) begin
      if (advance.late) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

endmodule

// ===== hdl/cpt_rotate.sv =====
// Park rotation: four products, then sum, floor shift and saturation.
module cpt_rotate #(
   parameter int SAMPLE_BITS = cpt_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                               clock,
   input  cpt_pkg::cpt_stage_en_type                          advance,
   input  logic signed [cpt_pkg::TRIG_W-1:0]                  cos_val,
   input  logic signed [cpt_pkg::TRIG_W-1:0]                  sin_val,
   input  logic signed [SAMPLE_BITS+cpt_pkg::XY_EXTRA_BITS-1:0] x_val,
   input  logic signed [SAMPLE_BITS+cpt_pkg::XY_EXTRA_BITS-1:0] y_val,
   output logic signed [SAMPLE_BITS-1:0]                      direct_ff,
   output logic signed [SAMPLE_BITS-1:0]                      quadrature_ff
);

   localparam int XY_W   = SAMPLE_BITS + cpt_pkg::XY_EXTRA_BITS;
   localparam int PROD_W = cpt_pkg::TRIG_W + XY_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int WIDE_W = SUM_W - cpt_pkg::ROTATE_SHIFT;
   localparam logic signed [WIDE_W-1:0] MAX_WIDE = WIDE_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [WIDE_W-1:0] MIN_WIDE = -MAX_WIDE - WIDE_W'(1);

   logic signed [PROD_W-1:0] cx_in, sy_in, cy_in, sx_in;
   logic signed [PROD_W-1:0] cx_ff, sy_ff, cy_ff, sx_ff;

   assign cx_in = cos_val * x_val;
   assign sy_in = sin_val * y_val;
   assign cy_in = cos_val * y_val;
   assign sx_in = sin_val * x_val;

   always_ff @(posedge clock) begin
      if (advance.early) begin
         cx_ff <= cx_in;
         sy_ff <= sy_in;
         cy_ff <= cy_in;
         sx_ff <= sx_in;
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] clamp(
      input logic signed [WIDE_W-1:0] v
   );
      logic signed [WIDE_W-1:0] r;
      r = v;
      if (v > MAX_WIDE) begin
         r = MAX_WIDE;
      end else if (v < MIN_WIDE) begin
         r = MIN_WIDE;
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

   logic signed [SUM_W-1:0]       d_sum;
   logic signed [SUM_W-1:0]       q_sum;
   logic signed [WIDE_W-1:0]      d_wide;
   logic signed [WIDE_W-1:0]      q_wide;
   logic signed [SAMPLE_BITS-1:0] direct_in;
   logic signed [SAMPLE_BITS-1:0] quadrature_in;

   assign d_sum  = SUM_W'(cx_ff) + SUM_W'(sy_ff);
   assign q_sum  = SUM_W'(cy_ff) - SUM_W'(sx_ff);
   // drop the low bits: floor division on two's complement
   assign d_wide = d_sum[SUM_W-1:cpt_pkg::ROTATE_SHIFT];
   assign q_wide = q_sum[SUM_W-1:cpt_pkg::ROTATE_SHIFT];
   assign direct_in     = clamp(d_wide);
   assign quadrature_in = clamp(q_wide);

   always_ff @(posedge clock) begin
      if (advance.late) begin
         direct_ff     <= direct_in;
         quadrature_ff <= quadrature_in;
      end
   end

endmodule

// ===== hdl/clarke_park_transform_unit.sv =====
// Throughput: one item per cycle while rsp_stall is low; five register stages
// (offset add, table bank read with Clarke multiply, bank select, rotation products,
// sum and saturate).
// A stalled output backs up stage by stage; empty stages keep filling.
// Reset clears the stage valid bits and the angle offset; the sine table is constant.
// Top level of the amplitude-invariant Clarke-Park transform pipeline.
`include "assert_macros.svh"

module clarke_park_transform_unit #(
   parameter int SINE_INDEX_BITS = cpt_pkg::SINE_INDEX_BITS_DEFAULT,
   parameter int SAMPLE_BITS     = cpt_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cpt_pkg::ANGLE_W-1:0]       req_electrical_angle,
   input  logic signed [SAMPLE_BITS-1:0]     req_phase_u_current,
   input  logic signed [SAMPLE_BITS-1:0]     req_phase_v_current,
   input  logic signed [SAMPLE_BITS-1:0]     req_phase_w_current,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]     rsp_direct_current,
   output logic signed [SAMPLE_BITS-1:0]     rsp_quadrature_current,
   input  logic                              csr_write_enable,
   input  logic [cpt_pkg::ANGLE_W-1:0]       csr_write_data
);

   localparam int ANGLE_W = cpt_pkg::ANGLE_W;
   localparam int SX_W    = SAMPLE_BITS + 2;
   localparam int DY_W    = SAMPLE_BITS + 1;
   localparam int XP_W    = SX_W + cpt_pkg::COEF_W;
   localparam int YP_W    = DY_W + cpt_pkg::COEF_W;
   localparam int XY_W    = SAMPLE_BITS + cpt_pkg::XY_EXTRA_BITS;
   localparam int P_W     = SINE_INDEX_BITS + 2;

   // Angle offset register
   logic [ANGLE_W-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_write_enable) begin
         offset_ff <= csr_write_data;
      end
   end

   // Stage valids and advance enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   // a stage advances when it is empty or the next one advances
   assign adv5 = !s5_valid_ff || !rsp_stall;
   assign adv4 = !s4_valid_ff || adv5;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_stall = !adv1;
   assign rsp_valid = s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (adv4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (adv5) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   // Stage 1: phase index and Clarke sums
   logic [ANGLE_W-1:0]         angle_sum;
   logic [P_W-1:0]             phase;
   logic [1:0]                 quad_ff;
   logic [SINE_INDEX_BITS-1:0] k_ff;
   logic signed [SX_W-1:0]     sumx_in, sumx_ff;
   logic signed [DY_W-1:0]     diffy_in, diffy_ff;

   assign angle_sum = req_electrical_angle + offset_ff;
   assign phase     = angle_sum[ANGLE_W-1 -: P_W];
   assign sumx_in   = SX_W'(req_phase_u_current) + SX_W'(req_phase_u_current)
                    - SX_W'(req_phase_v_current) - SX_W'(req_phase_w_current);
   assign diffy_in  = DY_W'(req_phase_v_current) - DY_W'(req_phase_w_current);

   always_ff @(posedge clock) begin
      if (adv1) begin
         quad_ff  <= phase[P_W-1 -: 2];
         k_ff     <= phase[SINE_INDEX_BITS-1:0];
         sumx_ff  <= sumx_in;
         diffy_ff <= diffy_in;
      end
   end

   // Stage 2: scale by 1/3 and 1/sqrt3, floor to Q16; stage 3 holds X and Y
   logic signed [XP_W-1:0] xprod;
   logic signed [YP_W-1:0] yprod;
   logic signed [XY_W-1:0] x2_in, y2_in, x2_ff, y2_ff, x3_ff, y3_ff;

   assign xprod = sumx_ff * cpt_pkg::THIRD_Q30;
   assign yprod = diffy_ff * cpt_pkg::INV_SQRT3_Q30;
   assign x2_in = xprod[XP_W-1:cpt_pkg::CLARKE_SHIFT];
   assign y2_in = {yprod[YP_W-1], yprod[YP_W-1:cpt_pkg::CLARKE_SHIFT]};

   always_ff @(posedge clock) begin
      if (adv2) begin
         x2_ff <= x2_in;
         y2_ff <= y2_in;
      end
      if (adv3) begin
         x3_ff <= x2_ff;
         y3_ff <= y2_ff;
      end
   end

   // Stages 2 and 3: sine and cosine lookup
   cpt_pkg::cpt_stage_en_type              rom_en;
   cpt_pkg::cpt_stage_en_type              rot_en;
   logic signed [cpt_pkg::TRIG_W-1:0]      sin_val;
   logic signed [cpt_pkg::TRIG_W-1:0]      cos_val;

   assign rom_en.early = adv2;
   assign rom_en.late  = adv3;
   assign rot_en.early = adv4;
   assign rot_en.late  = adv5;

   cpt_sine_rom #(
      .SINE_INDEX_BITS (SINE_INDEX_BITS)
   ) u_sine_rom (
      .clock   (clock),
      .advance (rom_en),
      .quad    (quad_ff),
      .k       (k_ff),
      .sin_ff  (sin_val),
      .cos_ff  (cos_val)
   );

   // Stages 4 and 5: rotation into the d-q frame
   cpt_rotate #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rotate (
      .clock         (clock),
      .advance       (rot_en),
      .cos_val       (cos_val),
      .sin_val       (sin_val),
      .x_val         (x3_ff),
      .y_val         (y3_ff),
      .direct_ff     (rsp_direct_current),
      .quadrature_ff (rsp_quadrature_current)
   );

   `CPT_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_valid && !req_stall, s1_valid_ff, "accepted transfer did not reach stage 1")
   `CPT_ASSERT_IMPLY(a_stall_only_full, clock, reset, req_stall, s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && s5_valid_ff && rsp_stall, "input stalled with a bubble in the pipeline")
   `CPT_ASSERT_NEXT(a_blocked_s4_holds, clock, reset, s4_valid_ff && !adv5, s4_valid_ff, "blocked stage 4 item dropped")

endmodule

// ===== verif/clarke_park_transform_unit_test.sv =====
// Testbench for the Clarke-Park transform unit: random and directed current samples, scoreboard.
module clarke_park_transform_unit_test;

   localparam int SINE_INDEX_BITS = cpt_pkg::SINE_INDEX_BITS_DEFAULT;
   localparam int SAMPLE_BITS     = cpt_pkg::SAMPLE_BITS_DEFAULT;
   localparam int ANGLE_W         = cpt_pkg::ANGLE_W;
   localparam int QUARTER_N       = 1 << SINE_INDEX_BITS;
   localparam int PHASE_W         = SINE_INDEX_BITS + 2;
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int ITEMS_PER_PHASE = 305;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [ANGLE_W-1:0]            angle_type;

   class dq_scoreboard_type;
      typedef struct {
         sample_type d;
         sample_type q;
      } dq_pair_type;

      longint quarter_sine[QUARTER_N+1];
      angle_type angle_offset;
      dq_pair_type expected_dq[$];
      int failures;
      int reported;

      function new();
         longint unsigned x;
         longint unsigned term;
         longint sum;
         longint entry;
         for (int k = 0; k <= QUARTER_N; k++) begin
            x = (longint'(k) * 64'd1686629713) >> SINE_INDEX_BITS;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 8; n++) begin
               term = (term * x) >> 30;
               term = (term * x) >> 30;
               term = term / longint'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            entry = (sum + 16384) >>> 15;
            if (entry < 0) entry = 0;
            if (entry > 32767) entry = 32767;
            quarter_sine[k] = entry;
         end
         angle_offset = '0;
         failures = 0;
         reported = 0;
      endfunction

      function void set_offset(angle_type value);
         angle_offset = value;
      endfunction

      function longint sine_of(logic [PHASE_W-1:0] phase);
         logic [1:0] quad;
         int k;
         longint v;
         quad = phase[PHASE_W-1 -: 2];
         k = int'(phase[SINE_INDEX_BITS-1:0]);
         v = quad[0] ? quarter_sine[QUARTER_N - k] : quarter_sine[k];
         return quad[1] ? -v : v;
      endfunction

      function sample_type clamp_sample(longint v);
         longint hi;
         longint lo;
         hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         return sample_type'(v);
      endfunction

      function void note_sample(angle_type angle, sample_type u, sample_type v,
                                sample_type w);
         angle_type rotated;
         logic [PHASE_W-1:0] phase;
         logic [PHASE_W-1:0] cos_phase;
         longint a, b, c, x, y, co, si;
         dq_pair_type pair;
         rotated = angle + angle_offset;
         phase = rotated[ANGLE_W-1 -: PHASE_W];
         cos_phase = phase + PHASE_W'(QUARTER_N);
         si = sine_of(phase);
         co = sine_of(cos_phase);
         a = longint'(u);
         b = longint'(v);
         c = longint'(w);
         x = ((2 * a - b - c) * 64'sd357913941) >>> 14;
         y = ((b - c) * 64'sd619925131) >>> 14;
         pair.d = clamp_sample((co * x + si * y) >>> 31);
         pair.q = clamp_sample((co * y - si * x) >>> 31);
         expected_dq.push_back(pair);
      endfunction

      function void check_dq(sample_type d, sample_type q);
         dq_pair_type pair;
         if (expected_dq.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("unexpected dq transfer: d=%0d q=%0d", d, q);
            end
            return;
         end
         pair = expected_dq.pop_front();
         if (pair.d !== d || pair.q !== q) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("dq mismatch: expected d=%0d q=%0d, got d=%0d q=%0d",
                        pair.d, pair.q, d, q);
            end
         end
      endfunction

      function int pending();
         return expected_dq.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   angle_type  req_electrical_angle = '0;
   sample_type req_phase_u_current = '0;
   sample_type req_phase_v_current = '0;
   sample_type req_phase_w_current = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_direct_current;
   sample_type rsp_quadrature_current;
   logic       csr_write_enable = 1'b0;
   angle_type  csr_write_data = '0;

   logic idle_on = 1'b1;
   logic hold_req = 1'b0;
   int   hold_count = 0;
   int   cycle_count = 0;

   dq_scoreboard_type sb = new();

   clarke_park_transform_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_electrical_angle   (req_electrical_angle),
      .req_phase_u_current    (req_phase_u_current),
      .req_phase_v_current    (req_phase_v_current),
      .req_phase_w_current    (req_phase_w_current),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_direct_current     (rsp_direct_current),
      .rsp_quadrature_current (rsp_quadrature_current),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Observe both channels on the edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_sample(req_electrical_angle, req_phase_u_current,
                           req_phase_v_current, req_phase_w_current);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_dq(rsp_direct_current, rsp_quadrature_current);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         if (!hold_req) hold_count <= 0;
         rsp_stall <= idle_on && ($urandom_range(99) < 35);
      end
   end

   task automatic send_item(angle_type angle, sample_type u, sample_type v, sample_type w);
      while (idle_on && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_electrical_angle <= angle;
      req_phase_u_current <= u;
      req_phase_v_current <= v;
      req_phase_w_current <= w;
      // hold the payload until the transfer
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_levels(angle_type angle, int u, int v, int w);
      send_item(angle, sample_type'(u), sample_type'(v), sample_type'(w));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_offset(angle_type value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_offset(value);
   endtask

   function automatic sample_type pick_extreme();
      case ($urandom_range(4))
         0: return sample_type'(-32768);
         1: return sample_type'(-1);
         2: return sample_type'(0);
         3: return sample_type'(1);
         default: return sample_type'(32767);
      endcase
   endfunction

   task automatic send_random(int count);
      angle_type angle;
      int iu, iv, iw;
      for (int i = 0; i < count; i++) begin
         angle = angle_type'($urandom);
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               send_item(angle, sample_type'($urandom), sample_type'($urandom),
                         sample_type'($urandom));
            end
            5, 6, 7: begin
               // roughly balanced three-phase set
               iu = int'($urandom_range(40000)) - 20000;
               iv = int'($urandom_range(40000)) - 20000;
               iw = -(iu + iv);
               if (iw > 32767) iw = 32767;
               if (iw < -32768) iw = -32768;
               send_item(angle, sample_type'(iu), sample_type'(iv), sample_type'(iw));
            end
            8: begin
               send_item(angle, pick_extreme(), pick_extreme(), pick_extreme());
            end
            default: begin
               // land near a quadrant boundary
               angle = angle_type'(int'($urandom_range(3)) * 16384
                                   + int'($urandom_range(31)) - 16);
               send_item(angle, sample_type'($urandom), sample_type'($urandom),
                         sample_type'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      angle_type phase_offset[6];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_levels(16'h0000, 0, 0, 0);
      send_levels(16'h0000, 32767, -32768, -32768);
      send_levels(16'h0000, -32768, 32767, 32767);
      send_levels(16'h4000, 32767, -32768, -32768);
      send_levels(16'h8000, 0, 32767, -32768);
      send_levels(16'hC000, 0, -32768, 32767);
      send_levels(16'hFFFF, 32767, 32767, 32767);
      send_levels(16'h3FFF, -32768, -32768, -32768);
      send_levels(16'h000F, 1000, -500, -500);
      send_levels(16'h0010, 1000, -500, -500);
      send_levels(16'h7FF0, 12345, -20000, 7655);
      send_levels(16'hBFFF, -1, -1, 2);
      send_levels(16'h2000, 32767, 0, -32767);
      send_levels(16'h6000, -32768, 32767, 0);
      drain();

      // offset wraps the angle around one turn
      write_offset(16'hFFFF);
      send_levels(16'h0000, 20000, -10000, -10000);
      send_levels(16'h0001, 20000, -10000, -10000);
      send_levels(16'h4000, -32768, 0, 32767);
      send_levels(16'hFFFF, 32767, -32768, 0);
      drain();

      phase_offset[0] = angle_type'($urandom);
      phase_offset[1] = 16'h0000;
      phase_offset[2] = 16'h8000;
      phase_offset[3] = angle_type'($urandom);
      phase_offset[4] = 16'hFFFF;
      phase_offset[5] = angle_type'($urandom);
      for (int ph = 0; ph < 6; ph++) begin
         write_offset(phase_offset[ph]);
         idle_on <= (ph != 1);
         if (ph == 2) hold_req <= 1'b1;
         send_random(ITEMS_PER_PHASE);
         if (ph == 2) begin
            while (hold_count < HOLD_CYCLES) @(posedge clock);
            hold_req <= 1'b0;
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
